[hw/rtl/depth_registration_zbuffer_assert.svh]
// ----------------------------------------------------------------------------
// Depth registration z-buffer assertion macros
// Concurrent assertion wrappers that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef DEPTH_REGISTRATION_ZBUFFER_ASSERT_SVH
`define DEPTH_REGISTRATION_ZBUFFER_ASSERT_SVH
`ifndef SYNTH
`define DRZ_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("depth registration assertion failed");
`define DRZ_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("depth registration assertion failed");
`else
`define DRZ_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define DRZ_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

[hw/rtl/drz_pkg.sv]
// ----------------------------------------------------------------------------
// Depth registration z-buffer package
// Field widths, register indexes, item codes, states and shared types.
// ----------------------------------------------------------------------------
package drz_pkg;

   localparam int COL_W      = 10;
   localparam int ROW_W      = 9;
   localparam int DEPTH_W    = 16;
   localparam int COEF_W     = 32;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_IDX_W  = 3;
   localparam int IMG_W_W    = 11;
   localparam int IMG_H_W    = 10;
   localparam int A_W        = COL_W + DEPTH_W;
   localparam int B_W        = ROW_W + DEPTH_W;
   localparam int P_W        = 62;
   localparam int LIM_W      = 16;

   typedef enum logic {
      FUNC_PROJECT = 1'b0,
      FUNC_READ    = 1'b1
   } func_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ROW0_LO      = 3'd0,
      REG_ROW0_HI      = 3'd1,
      REG_ROW1_LO      = 3'd2,
      REG_ROW1_HI      = 3'd3,
      REG_ROW2_LO      = 3'd4,
      REG_ROW2_HI      = 3'd5,
      REG_IMAGE_WIDTH  = 3'd6,
      REG_IMAGE_HEIGHT = 3'd7
   } csr_reg_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCALE,
      ST_MUL,
      ST_SUM,
      ST_DIV_LOAD,
      ST_DIV,
      ST_CHECK,
      ST_UPDATE,
      ST_RD_RET
   } state_type;

   typedef logic [3:0][COEF_W-1:0] coef_row_type;

   typedef struct packed {
      logic load;
      logic step;
   } div_ctrl_type;

endpackage

[hw/rtl/depth_registration_zbuffer.sv]
// ----------------------------------------------------------------------------
// Depth-to-color registration with z-buffer
// Projects depth pixels through a 3x4 fixed-point matrix and keeps the
// nearest depth per target pixel; read items return and clear an entry.
// ----------------------------------------------------------------------------
// After reset the block sweeps the z-buffer RAM to zero, one entry per cycle,
// over all MAX_WIDTH*MAX_HEIGHT entries and stalls input items during the pass.
// Items are then handled one at a time. A read item reads the RAM in IDLE and
// then returns and clears the entry in RD_RET, where it waits while an earlier
// result is still stalled. A depth pixel with zero depth is dropped in IDLE.
// Any other depth pixel is scaled in SCALE, runs the three matrix rows through
// MUL and SUM on a set of three multipliers, and ends in DIV_LOAD when pz is
// not positive; else Q steps of the bit-serial dividers follow, where
// Q = clog2(max(MAX_WIDTH, MAX_HEIGHT)+1), and a target inside the image
// gets a read-modify-write on the RAM in CHECK and UPDATE; a target outside
// the image ends in CHECK.
module depth_registration_zbuffer #(
   parameter int MAX_WIDTH      = 1024,
   parameter int MAX_HEIGHT     = 512,
   parameter int COEF_FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_func,
   input  logic [drz_pkg::COL_W-1:0]           req_col,
   input  logic [drz_pkg::ROW_W-1:0]           req_row,
   input  logic [drz_pkg::DEPTH_W-1:0]         req_depth,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [drz_pkg::DEPTH_W-1:0]         rsp_registered_depth,
   input  logic                                csr_we,
   input  logic [drz_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [drz_pkg::CSR_DATA_W-1:0]      csr_data
);

   `include "depth_registration_zbuffer_assert.svh"

   localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
   localparam int QBITS   = $clog2(MAX_DIM + 1);
   localparam int CNT_W   = $clog2(QBITS);
   localparam int P_W     = drz_pkg::P_W;
   localparam logic [drz_pkg::COEF_W-1:0] COEF_ONE =
      drz_pkg::COEF_W'(1 << COEF_FRAC_BITS);

   drz_pkg::state_type     state_ff, state_in;
   drz_pkg::coef_row_type  coef_ff [3];
   logic [drz_pkg::IMG_W_W-1:0] image_width_ff;
   logic [drz_pkg::IMG_H_W-1:0] image_height_ff;

   logic [ADDR_W-1:0]          clr_ff;
   logic [drz_pkg::COL_W-1:0]  u_ff;
   logic [drz_pkg::ROW_W-1:0]  v_ff;
   logic [drz_pkg::DEPTH_W-1:0] z_ff;
   logic [drz_pkg::A_W-1:0]    a_ff;
   logic [drz_pkg::B_W-1:0]    b_ff;
   logic [1:0]                 row_ff;
   logic signed [P_W-1:0]      pr0_ff, pr1_ff, pr2_ff, c3_ff;
   logic signed [P_W-1:0]      px_ff, py_ff, pz_ff, sum;
   logic [CNT_W-1:0]           cnt_ff;
   logic [ADDR_W-1:0]          addr_ff;
   logic                       rd_in_range_ff;
   logic                       rsp_valid_ff;
   logic [drz_pkg::DEPTH_W-1:0] rsp_data_ff;

   drz_pkg::coef_row_type      sel_row;
   drz_pkg::div_ctrl_type      div_ctrl;
   logic [P_W-1:0]             px_mag, py_mag, pz_mag, zsh;
   logic [QBITS-1:0]           qx, qy;
   logic                       ovx, ovy;
   logic [drz_pkg::LIM_W-1:0]  wlim, hlim;
   logic                       target_ok, req_accept, rd_in_range, ret_ok;
   logic [drz_pkg::DEPTH_W-1:0] zt, mem_rdata, mem_wdata;
   logic [ADDR_W-1:0]          mem_addr, rd_addr, tgt_addr;
   logic                       mem_en, mem_we, rsp_load;

   assign req_accept  = req_valid && !req_stall;
   assign ret_ok      = !rsp_valid_ff || !rsp_stall;
   assign rd_in_range = (32'(req_col) < MAX_WIDTH) && (32'(req_row) < MAX_HEIGHT);
   assign rd_addr     = ADDR_W'(32'(req_row) * MAX_WIDTH + 32'(req_col));
   assign tgt_addr    = ADDR_W'(32'(qy) * MAX_WIDTH + 32'(qx));

   assign px_mag = px_ff[P_W-1] ? P_W'(-px_ff) : P_W'(px_ff);
   assign py_mag = py_ff[P_W-1] ? P_W'(-py_ff) : P_W'(py_ff);
   assign pz_mag = P_W'(pz_ff);

   assign wlim = (drz_pkg::LIM_W'(image_width_ff) < drz_pkg::LIM_W'(MAX_WIDTH)) ?
                 drz_pkg::LIM_W'(image_width_ff) : drz_pkg::LIM_W'(MAX_WIDTH);
   assign hlim = (drz_pkg::LIM_W'(image_height_ff) < drz_pkg::LIM_W'(MAX_HEIGHT)) ?
                 drz_pkg::LIM_W'(image_height_ff) : drz_pkg::LIM_W'(MAX_HEIGHT);

   // A negative numerator with a nonzero quotient magnitude truncates below zero.
   assign target_ok = !ovx && !ovy &&
                      !(px_ff[P_W-1] && (qx != '0)) && !(py_ff[P_W-1] && (qy != '0)) &&
                      (drz_pkg::LIM_W'(qx) < wlim) && (drz_pkg::LIM_W'(qy) < hlim);

   assign zsh = P_W'(pz_mag >> COEF_FRAC_BITS);
   assign zt  = (|zsh[P_W-1:drz_pkg::DEPTH_W]) ? '1 : zsh[drz_pkg::DEPTH_W-1:0];

   assign sum = pr0_ff + pr1_ff + pr2_ff + c3_ff;

   always_comb begin
      case (row_ff)
         2'd0:    sel_row = coef_ff[0];
         2'd1:    sel_row = coef_ff[1];
         default: sel_row = coef_ff[2];
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= drz_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      div_ctrl  = '0;
      mem_en    = 1'b0;
      mem_we    = 1'b0;
      mem_addr  = addr_ff;
      mem_wdata = '0;
      rsp_load  = 1'b0;
      case (state_ff)
         drz_pkg::ST_CLEAR: begin
            mem_en   = 1'b1;
            mem_we   = 1'b1;
            mem_addr = clr_ff;
            if (clr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = drz_pkg::ST_IDLE;
            end
         end
         drz_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            mem_addr  = rd_addr;
            if (req_valid) begin
               if (req_func == drz_pkg::FUNC_READ) begin
                  mem_en   = 1'b1;
                  state_in = drz_pkg::ST_RD_RET;
               end else if (req_depth != '0) begin
                  state_in = drz_pkg::ST_SCALE;
               end
            end
         end
         drz_pkg::ST_SCALE: begin
            state_in = drz_pkg::ST_MUL;
         end
         drz_pkg::ST_MUL: begin
            state_in = drz_pkg::ST_SUM;
         end
         drz_pkg::ST_SUM: begin
            state_in = (row_ff == 2'd2) ? drz_pkg::ST_DIV_LOAD : drz_pkg::ST_MUL;
         end
         drz_pkg::ST_DIV_LOAD: begin
            if (pz_ff[P_W-1] || (pz_ff == '0)) begin
               state_in = drz_pkg::ST_IDLE;
            end else begin
               div_ctrl.load = 1'b1;
               state_in      = drz_pkg::ST_DIV;
            end
         end
         drz_pkg::ST_DIV: begin
            div_ctrl.step = 1'b1;
            if (cnt_ff == CNT_W'(QBITS - 1)) begin
               state_in = drz_pkg::ST_CHECK;
            end
         end
         drz_pkg::ST_CHECK: begin
            mem_addr = tgt_addr;
            if (target_ok) begin
               mem_en   = 1'b1;
               state_in = drz_pkg::ST_UPDATE;
            end else begin
               state_in = drz_pkg::ST_IDLE;
            end
         end
         drz_pkg::ST_UPDATE: begin
            mem_wdata = zt;
            if ((mem_rdata == '0) || (mem_rdata > zt)) begin
               mem_en = 1'b1;
               mem_we = 1'b1;
            end
            state_in = drz_pkg::ST_IDLE;
         end
         drz_pkg::ST_RD_RET: begin
            if (ret_ok) begin
               rsp_load = 1'b1;
               mem_en   = rd_in_range_ff;
               mem_we   = rd_in_range_ff;
               state_in = drz_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = drz_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff[0]      <= {32'd0, 32'd0, 32'd0, COEF_ONE};
         coef_ff[1]      <= {32'd0, 32'd0, COEF_ONE, 32'd0};
         coef_ff[2]      <= {32'd0, COEF_ONE, 32'd0, 32'd0};
         image_width_ff  <= drz_pkg::IMG_W_W'(640);
         image_height_ff <= drz_pkg::IMG_H_W'(480);
      end else if (csr_we) begin
         case (csr_index)
            drz_pkg::REG_ROW0_LO:      coef_ff[0][1:0] <= csr_data;
            drz_pkg::REG_ROW0_HI:      coef_ff[0][3:2] <= csr_data;
            drz_pkg::REG_ROW1_LO:      coef_ff[1][1:0] <= csr_data;
            drz_pkg::REG_ROW1_HI:      coef_ff[1][3:2] <= csr_data;
            drz_pkg::REG_ROW2_LO:      coef_ff[2][1:0] <= csr_data;
            drz_pkg::REG_ROW2_HI:      coef_ff[2][3:2] <= csr_data;
            drz_pkg::REG_IMAGE_WIDTH:  image_width_ff  <= csr_data[drz_pkg::IMG_W_W-1:0];
            drz_pkg::REG_IMAGE_HEIGHT: image_height_ff <= csr_data[drz_pkg::IMG_H_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == drz_pkg::ST_CLEAR) begin
            clr_ff <= clr_ff + ADDR_W'(1);
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         u_ff           <= req_col;
         v_ff           <= req_row;
         z_ff           <= req_depth;
         rd_in_range_ff <= rd_in_range;
      end
      if (state_ff == drz_pkg::ST_SCALE) begin
         a_ff   <= drz_pkg::A_W'(u_ff) * drz_pkg::A_W'(z_ff);
         b_ff   <= drz_pkg::B_W'(v_ff) * drz_pkg::B_W'(z_ff);
         row_ff <= 2'd0;
      end
      if (state_ff == drz_pkg::ST_MUL) begin
         pr0_ff <= P_W'($signed(sel_row[0]) * $signed({1'b0, a_ff}));
         pr1_ff <= P_W'($signed(sel_row[1]) * $signed({1'b0, b_ff}));
         pr2_ff <= P_W'($signed(sel_row[2]) * $signed({1'b0, z_ff}));
         c3_ff  <= P_W'($signed(sel_row[3]));
      end
      if (state_ff == drz_pkg::ST_SUM) begin
         case (row_ff)
            2'd0:    px_ff <= sum;
            2'd1:    py_ff <= sum;
            default: pz_ff <= sum;
         endcase
         row_ff <= row_ff + 2'd1;
      end
      if (div_ctrl.load) begin
         cnt_ff <= '0;
      end else if (div_ctrl.step) begin
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
      if (state_ff == drz_pkg::ST_CHECK) begin
         addr_ff <= tgt_addr;
      end else if (req_accept) begin
         addr_ff <= rd_addr;
      end
      if (rsp_load) begin
         rsp_data_ff <= rd_in_range_ff ? mem_rdata : '0;
      end
   end

   drz_div #(.QBITS(QBITS)) u_div_x (
      .clock    (clock),
      .ctrl     (div_ctrl),
      .dividend (px_mag),
      .divisor  (pz_mag),
      .quotient (qx),
      .overflow (ovx)
   );

   drz_div #(.QBITS(QBITS)) u_div_y (
      .clock    (clock),
      .ctrl     (div_ctrl),
      .dividend (py_mag),
      .divisor  (pz_mag),
      .quotient (qy),
      .overflow (ovy)
   );

   drz_ram #(.WIDTH(drz_pkg::DEPTH_W), .DEPTH(DEPTH)) u_zbuf (
      .clock (clock),
      .en    (mem_en),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_registered_depth = rsp_data_ff;

   `DRZ_ASSERT_IMP(a_clear_stalls, clock, reset, state_ff == drz_pkg::ST_CLEAR, req_stall)
   `DRZ_ASSERT_IMP(a_depth_write_in_update, clock, reset, mem_we && (mem_wdata != '0), state_ff == drz_pkg::ST_UPDATE)
   `DRZ_ASSERT_NXT(a_read_goes_to_return, clock, reset, req_accept && (req_func == drz_pkg::FUNC_READ), state_ff == drz_pkg::ST_RD_RET)
   `DRZ_ASSERT_NXT(a_div_ends_in_check, clock, reset, (state_ff == drz_pkg::ST_DIV) && (cnt_ff == CNT_W'(QBITS - 1)), state_ff == drz_pkg::ST_CHECK)

endmodule

[hw/rtl/drz_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One access per cycle, write or read, with registered read data.
// ----------------------------------------------------------------------------
module drz_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

[hw/rtl/drz_div.sv]
// ----------------------------------------------------------------------------
// Restoring divider
// Produces one quotient bit per step for a positive divisor and flags
// quotients that do not fit in the quotient width.
// ----------------------------------------------------------------------------
module drz_div #(
   parameter int QBITS = 11
) (
   input  logic                      clock,
   input  drz_pkg::div_ctrl_type     ctrl,
   input  logic [drz_pkg::P_W-1:0]   dividend,
   input  logic [drz_pkg::P_W-1:0]   divisor,
   output logic [QBITS-1:0]          quotient,
   output logic                      overflow
);

   localparam int DW = drz_pkg::P_W + QBITS;

   logic [drz_pkg::P_W-1:0] rem_ff, rem_in;
   logic [DW-1:0]           dsh_ff, dsh_in;
   logic [QBITS-1:0]        q_ff, q_in;
   logic                    ovf_ff, ovf_in;

   always_comb begin
      rem_in = rem_ff;
      dsh_in = dsh_ff;
      q_in   = q_ff;
      ovf_in = ovf_ff;
      if (ctrl.load) begin
         rem_in = dividend;
         dsh_in = DW'(divisor) << (QBITS - 1);
         q_in   = '0;
         ovf_in = {1'b0, DW'(dividend)} >= ((DW + 1)'(divisor) << QBITS);
      end else if (ctrl.step) begin
         if (DW'(rem_ff) >= dsh_ff) begin
            rem_in = rem_ff - drz_pkg::P_W'(dsh_ff);
            q_in   = {q_ff[QBITS-2:0], 1'b1};
         end else begin
            q_in   = {q_ff[QBITS-2:0], 1'b0};
         end
         dsh_in = dsh_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
      ovf_ff <= ovf_in;
   end

   assign quotient = q_ff;
   assign overflow = ovf_ff;

endmodule
